### rtl/pes_hdr_pkg.sv
// ----------------------------------------------------------------------------
// pes_hdr_pkg: shared types and constants of the PES header field parser
// record type, field codes and output queue sizing
// ----------------------------------------------------------------------------
package pes_hdr_pkg;

	localparam int InDataW   = 8;
	localparam int OutDataW  = 72;
	localparam int FifoDepth = 4;
	localparam int FifoAw    = $clog2(FifoDepth);
	localparam int FifoCw    = $clog2(FifoDepth + 1);

	// field codes of a record
	localparam logic [4:0] CodeStart    = 5'd0;
	localparam logic [4:0] CodeStreamId = 5'd1;
	localparam logic [4:0] CodeLength   = 5'd2;
	localparam logic [4:0] CodeFlag1    = 5'd3;
	localparam logic [4:0] CodeFlag2    = 5'd4;
	localparam logic [4:0] CodeHdrLen   = 5'd5;
	localparam logic [4:0] CodePts      = 5'd6;
	localparam logic [4:0] CodeDts      = 5'd7;
	localparam logic [4:0] CodeEscrBase = 5'd8;
	localparam logic [4:0] CodeEscrExt  = 5'd9;
	localparam logic [4:0] CodeEsRate   = 5'd10;
	localparam logic [4:0] CodeTrick    = 5'd11;
	localparam logic [4:0] CodeCopy     = 5'd12;
	localparam logic [4:0] CodeCrc      = 5'd13;
	localparam logic [4:0] CodeExtFlags = 5'd14;
	localparam logic [4:0] CodePrivHi   = 5'd15;
	localparam logic [4:0] CodePrivLo   = 5'd16;
	localparam logic [4:0] CodePackLen  = 5'd17;
	localparam logic [4:0] CodeSeqCnt   = 5'd18;
	localparam logic [4:0] CodeMpegId   = 5'd19;
	localparam logic [4:0] CodeStuffLen = 5'd20;
	localparam logic [4:0] CodePstd     = 5'd21;
	localparam logic [4:0] CodeExt2Len  = 5'd22;
	localparam logic [4:0] CodeBadStart = 5'd23;

	typedef struct packed {
		logic [4:0]  code;
		logic [63:0] value;
		logic        last;
	} rec_t;

	// up to two records per accepted byte, second only with first
	typedef struct packed {
		logic v0;
		logic v1;
		rec_t r0;
		rec_t r1;
	} push_t;

endpackage

### rtl/pes_hdr_parse.sv
// ----------------------------------------------------------------------------
// pes_hdr_parse: byte-wise PES header parse state machine
// updates the parse state on each accepted byte and emits up to two records
// ----------------------------------------------------------------------------
module pes_hdr_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_acc,
	input  logic [7:0]            in_byte,
	input  logic                  in_first,
	output pes_hdr_pkg::push_t    push
);

	typedef enum logic [4:0] {
		StIdle     = 5'd0,
		StStart    = 5'd1,
		StId       = 5'd2,
		StLen      = 5'd3,
		StFlag1    = 5'd4,
		StFlag2    = 5'd5,
		StHlen     = 5'd6,
		StPts      = 5'd7,
		StDts      = 5'd8,
		StEscr     = 5'd9,
		StRate     = 5'd10,
		StTrick    = 5'd11,
		StCopy     = 5'd12,
		StCrc      = 5'd13,
		StExt      = 5'd14,
		StPriv     = 5'd15,
		StPackLen  = 5'd16,
		StPackSkip = 5'd17,
		StSeq      = 5'd18,
		StPstd     = 5'd19,
		StExt2     = 5'd20,
		StDone     = 5'd21
	} step_t;

	step_t       step_q,  step_d;
	logic [3:0]  idx_q,   idx_d;
	logic [63:0] acc_q,   acc_d;
	logic [7:0]  sid_q,   sid_d;
	logic [7:0]  opt_q,   opt_d;
	logic [7:0]  ext_q,   ext_d;
	logic [7:0]  hbl_q,   hbl_d;

	logic [63:0] a;
	step_t       nx;
	logic [2:0]  mode;
	logic [4:0]  sub;

	function automatic logic has_opt(input logic [7:0] id);
		return !(id == 8'hBC || id == 8'hBE || id == 8'hBF || id == 8'hF0 ||
		         id == 8'hF1 || id == 8'hF2 || id == 8'hF8 || id == 8'hFF);
	endfunction

	// first present field after the given step, by the flag bytes
	function automatic step_t next_step(input step_t from, input logic [7:0] opt,
	                                    input logic [7:0] ext);
		logic [20:0] pres;
		step_t       res;
		pres = '0;
		res  = StDone;
		pres[StPts]     = opt[7];
		pres[StDts]     = opt[7] & opt[6];
		pres[StEscr]    = opt[5];
		pres[StRate]    = opt[4];
		pres[StTrick]   = opt[3];
		pres[StCopy]    = opt[2];
		pres[StCrc]     = opt[1];
		pres[StExt]     = opt[0];
		pres[StPriv]    = opt[0] & ext[7];
		pres[StPackLen] = opt[0] & ext[6];
		pres[StSeq]     = opt[0] & ext[5];
		pres[StPstd]    = opt[0] & ext[4];
		pres[StExt2]    = opt[0] & ext[0];
		for (int i = 20; i >= 7; i--) begin
			if (5'(i) > from && pres[i]) begin
				res = step_t'(5'(i));
			end
		end
		return res;
	endfunction

	function automatic pes_hdr_pkg::rec_t mk(input logic [4:0] c, input logic [63:0] v,
	                                         input logic l);
		pes_hdr_pkg::rec_t r;
		r.code  = c;
		r.value = v;
		r.last  = l;
		return r;
	endfunction

	assign a    = {acc_q[55:0], in_byte};
	assign mode = in_byte[7:5];

	always_comb begin
		step_d = step_q;
		idx_d  = idx_q;
		acc_d  = acc_q;
		sid_d  = sid_q;
		opt_d  = opt_q;
		ext_d  = ext_q;
		hbl_d  = hbl_q;
		nx     = StDone;
		sub    = '0;
		push   = '0;

		case (mode)
			3'd0, 3'd1, 3'd3, 3'd4: sub = in_byte[4:0];
			3'd2:                   sub = {in_byte[4:3], 3'b000};
			default:                sub = '0;
		endcase

		if (in_first) begin
			opt_d  = '0;
			ext_d  = '0;
			hbl_d  = '0;
			step_d = StStart;
			acc_d  = {56'd0, in_byte};
			idx_d  = 4'd1;
		end else begin
			if (step_q > StHlen && hbl_q != 8'd0) begin
				hbl_d = hbl_q - 8'd1;
			end
			case (step_q)
				StStart: begin
					if (idx_q < 4'd2) begin
						acc_d = a;
						idx_d = idx_q + 4'd1;
					end else begin
						idx_d   = '0;
						acc_d   = '0;
						push.v0 = 1'b1;
						if (a[23:0] == 24'd1) begin
							push.r0 = mk(pes_hdr_pkg::CodeStart, {40'd0, a[23:0]}, 1'b0);
							step_d  = StId;
						end else begin
							push.r0 = mk(pes_hdr_pkg::CodeBadStart, {40'd0, a[23:0]}, 1'b1);
							step_d  = StIdle;
						end
					end
				end
				StId: begin
					sid_d   = in_byte;
					push.v0 = 1'b1;
					push.r0 = mk(pes_hdr_pkg::CodeStreamId, {56'd0, in_byte}, !has_opt(in_byte));
					step_d  = StLen;
					idx_d   = '0;
					acc_d   = '0;
				end
				StLen: begin
					if (idx_q < 4'd1) begin
						acc_d = a;
						idx_d = 4'd1;
					end else begin
						push.v0 = 1'b1;
						push.r0 = mk(pes_hdr_pkg::CodeLength, {48'd0, a[15:0]}, !has_opt(sid_q));
						step_d  = has_opt(sid_q) ? StFlag1 : StDone;
						idx_d   = '0;
						acc_d   = '0;
					end
				end
				StFlag1: begin
					push.v0 = 1'b1;
					push.r0 = mk(pes_hdr_pkg::CodeFlag1, {58'd0, in_byte[5:0]}, 1'b0);
					step_d  = StFlag2;
					idx_d   = '0;
					acc_d   = '0;
				end
				StFlag2: begin
					opt_d   = in_byte;
					push.v0 = 1'b1;
					push.r0 = mk(pes_hdr_pkg::CodeFlag2, {56'd0, in_byte}, 1'b0);
					step_d  = StHlen;
					idx_d   = '0;
					acc_d   = '0;
				end
				StHlen: begin
					hbl_d   = in_byte;
					nx      = next_step(StHlen, opt_q, ext_q);
					push.v0 = 1'b1;
					push.r0 = mk(pes_hdr_pkg::CodeHdrLen, {56'd0, in_byte}, nx == StDone);
					step_d  = nx;
					idx_d   = '0;
					acc_d   = '0;
				end
				StPts, StDts: begin
					if (idx_q < 4'd4) begin
						acc_d = a;
						idx_d = idx_q + 4'd1;
					end else begin
						nx      = next_step(step_q, opt_q, ext_q);
						push.v0 = 1'b1;
						push.r0 = mk((step_q == StPts) ? pes_hdr_pkg::CodePts
						                               : pes_hdr_pkg::CodeDts,
						             {31'd0, a[35:33], a[31:17], a[15:1]}, nx == StDone);
						step_d  = nx;
						idx_d   = '0;
						acc_d   = '0;
					end
				end
				StEscr: begin
					if (idx_q < 4'd5) begin
						acc_d = a;
						idx_d = idx_q + 4'd1;
					end else begin
						nx      = next_step(StEscr, opt_q, ext_q);
						push.v0 = 1'b1;
						push.r0 = mk(pes_hdr_pkg::CodeEscrBase,
						             {31'd0, a[45:43], a[41:27], a[25:11]}, 1'b0);
						push.v1 = 1'b1;
						push.r1 = mk(pes_hdr_pkg::CodeEscrExt, {55'd0, a[9:1]}, nx == StDone);
						step_d  = nx;
						idx_d   = '0;
						acc_d   = '0;
					end
				end
				StRate: begin
					if (idx_q < 4'd2) begin
						acc_d = a;
						idx_d = idx_q + 4'd1;
					end else begin
						nx      = next_step(StRate, opt_q, ext_q);
						push.v0 = 1'b1;
						push.r0 = mk(pes_hdr_pkg::CodeEsRate, {42'd0, a[22:1]}, nx == StDone);
						step_d  = nx;
						idx_d   = '0;
						acc_d   = '0;
					end
				end
				StTrick: begin
					nx      = next_step(StTrick, opt_q, ext_q);
					push.v0 = 1'b1;
					push.r0 = mk(pes_hdr_pkg::CodeTrick, {56'd0, mode, sub}, nx == StDone);
					step_d  = nx;
					idx_d   = '0;
					acc_d   = '0;
				end
				StCopy: begin
					nx      = next_step(StCopy, opt_q, ext_q);
					push.v0 = 1'b1;
					push.r0 = mk(pes_hdr_pkg::CodeCopy, {57'd0, in_byte[6:0]}, nx == StDone);
					step_d  = nx;
					idx_d   = '0;
					acc_d   = '0;
				end
				StCrc: begin
					if (idx_q < 4'd1) begin
						acc_d = a;
						idx_d = 4'd1;
					end else begin
						nx      = next_step(StCrc, opt_q, ext_q);
						push.v0 = 1'b1;
						push.r0 = mk(pes_hdr_pkg::CodeCrc, {48'd0, a[15:0]}, nx == StDone);
						step_d  = nx;
						idx_d   = '0;
						acc_d   = '0;
					end
				end
				StExt: begin
					// the new extension flags already decide what follows
					ext_d   = in_byte;
					nx      = next_step(StExt, opt_q, in_byte);
					push.v0 = 1'b1;
					push.r0 = mk(pes_hdr_pkg::CodeExtFlags, {56'd0, in_byte}, nx == StDone);
					step_d  = nx;
					idx_d   = '0;
					acc_d   = '0;
				end
				StPriv: begin
					if (idx_q == 4'd7) begin
						push.v0 = 1'b1;
						push.r0 = mk(pes_hdr_pkg::CodePrivHi, a, 1'b0);
						acc_d   = '0;
						idx_d   = 4'd8;
					end else if (idx_q == 4'd15) begin
						nx      = next_step(StPriv, opt_q, ext_q);
						push.v0 = 1'b1;
						push.r0 = mk(pes_hdr_pkg::CodePrivLo, a, nx == StDone);
						step_d  = nx;
						idx_d   = '0;
						acc_d   = '0;
					end else begin
						acc_d = a;
						idx_d = idx_q + 4'd1;
					end
				end
				StPackLen: begin
					nx      = next_step(StPackSkip, opt_q, ext_q);
					push.v0 = 1'b1;
					push.r0 = mk(pes_hdr_pkg::CodePackLen, {56'd0, in_byte}, nx == StDone);
					idx_d   = '0;
					if (in_byte != 8'd0) begin
						step_d = StPackSkip;
						acc_d  = {56'd0, in_byte};
					end else begin
						step_d = nx;
						acc_d  = '0;
					end
				end
				StPackSkip: begin
					// pack header bytes are dropped, no records
					if (acc_q > 64'd1) begin
						acc_d = acc_q - 64'd1;
					end else begin
						step_d = next_step(StPackSkip, opt_q, ext_q);
						idx_d  = '0;
						acc_d  = '0;
					end
				end
				StSeq: begin
					if (idx_q < 4'd1) begin
						push.v0 = 1'b1;
						push.r0 = mk(pes_hdr_pkg::CodeSeqCnt, {57'd0, in_byte[6:0]}, 1'b0);
						idx_d   = 4'd1;
					end else begin
						nx      = next_step(StSeq, opt_q, ext_q);
						push.v0 = 1'b1;
						push.r0 = mk(pes_hdr_pkg::CodeMpegId, {63'd0, in_byte[6]}, 1'b0);
						push.v1 = 1'b1;
						push.r1 = mk(pes_hdr_pkg::CodeStuffLen, {58'd0, in_byte[5:0]},
						             nx == StDone);
						step_d  = nx;
						idx_d   = '0;
						acc_d   = '0;
					end
				end
				StPstd: begin
					if (idx_q < 4'd1) begin
						acc_d = a;
						idx_d = 4'd1;
					end else begin
						nx      = next_step(StPstd, opt_q, ext_q);
						push.v0 = 1'b1;
						push.r0 = mk(pes_hdr_pkg::CodePstd, {50'd0, a[13:0]}, nx == StDone);
						step_d  = nx;
						idx_d   = '0;
						acc_d   = '0;
					end
				end
				StExt2: begin
					nx      = next_step(StExt2, opt_q, ext_q);
					push.v0 = 1'b1;
					push.r0 = mk(pes_hdr_pkg::CodeExt2Len, {57'd0, in_byte[6:0]}, nx == StDone);
					step_d  = nx;
					idx_d   = '0;
					acc_d   = '0;
				end
				default: begin
				end
			endcase
		end

		if (!in_acc) begin
			push.v0 = 1'b0;
			push.v1 = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= StIdle;
			idx_q  <= '0;
			acc_q  <= '0;
			sid_q  <= '0;
			opt_q  <= '0;
			ext_q  <= '0;
			hbl_q  <= '0;
		end else if (in_acc) begin
			step_q <= step_d;
			idx_q  <= idx_d;
			acc_q  <= acc_d;
			sid_q  <= sid_d;
			opt_q  <= opt_d;
			ext_q  <= ext_d;
			hbl_q  <= hbl_d;
		end
	end

endmodule

### rtl/pes_hdr_fifo.sv
// ----------------------------------------------------------------------------
// pes_hdr_fifo: record queue between parser and output stream
// takes up to two records per cycle, hands out one per beat
// ----------------------------------------------------------------------------
module pes_hdr_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  pes_hdr_pkg::push_t  push,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output pes_hdr_pkg::rec_t   out_rec
);

	pes_hdr_pkg::rec_t mem [pes_hdr_pkg::FifoDepth];

	logic [pes_hdr_pkg::FifoAw-1:0] wp_q;
	logic [pes_hdr_pkg::FifoAw-1:0] rp_q;
	logic [pes_hdr_pkg::FifoCw-1:0] cnt_q;
	logic                           pop;
	logic [pes_hdr_pkg::FifoCw-1:0] n_push;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid & out_ready;
	assign out_rec   = mem[rp_q];
	// room needs space for two records, since one accepted byte can raise two
	assign room      = (cnt_q <= pes_hdr_pkg::FifoCw'(pes_hdr_pkg::FifoDepth - 2));
	assign n_push    = pes_hdr_pkg::FifoCw'(push.v0) + pes_hdr_pkg::FifoCw'(push.v1);

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem[wp_q] <= push.r0;
		end
		if (push.v1) begin
			mem[wp_q + pes_hdr_pkg::FifoAw'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + pes_hdr_pkg::FifoAw'(n_push);
			rp_q  <= rp_q + pes_hdr_pkg::FifoAw'(pop);
			cnt_q <= cnt_q + n_push - pes_hdr_pkg::FifoCw'(pop);
		end
	end

endmodule

### rtl/pes_header_field_parser.sv
// output: each record is registered in the record queue before it leaves on m_tdata
// throughput: one byte per cycle while s_tready is high; a byte may raise two records, drained at one per beat
// the input stalls only while the four-entry record queue has fewer than two free slots
// reset: arst_n clears parse state and queue; the parser then waits for a first byte
// ----------------------------------------------------------------------------
// pes_header_field_parser: MPEG-2 PES header field parser
// decodes header fields from a byte stream into coded field records
// ----------------------------------------------------------------------------
module pes_header_field_parser (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [pes_hdr_pkg::InDataW-1:0]  s_tdata,   // [7:0] packet_byte
	input  logic [0:0]                       s_tuser,   // [0] first_byte
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [pes_hdr_pkg::OutDataW-1:0] m_tdata,   // [4:0] field_code, [68:5] field_value
	output logic                             m_tlast    // last record of the header
);

	logic               in_acc;
	pes_hdr_pkg::push_t push;
	pes_hdr_pkg::rec_t  out_rec;

	assign in_acc = s_tvalid & s_tready;

	pes_hdr_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_acc   (in_acc),
		.in_byte  (s_tdata),
		.in_first (s_tuser[0]),
		.push     (push)
	);

	pes_hdr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_rec   (out_rec)
	);

	assign m_tdata = {3'b000, out_rec.value, out_rec.code};
	assign m_tlast = out_rec.last;

`ifndef ASSERT_OFF
	// records come only from an accepted beat
	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push.v0 |-> in_acc)
		else $error("record pushed without an accepted beat");

	// a second record never comes alone: it follows a first record that is not last, with the next code
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> (push.v0 && push.r1.code == push.r0.code + 5'd1 && !push.r0.last))
		else $error("second record out of order");

	// a bad start code always ends the header
	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push.v0 && push.r0.code == pes_hdr_pkg::CodeBadStart) |-> push.r0.last)
		else $error("bad start code record not last");

	// a first byte never produces records
	a_first_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_tuser[0]) |-> !push.v0)
		else $error("record on first byte");
`endif

endmodule

### verif/pes_header_field_parser_tb.sv
// ----------------------------------------------------------------------------
// pes_header_field_parser_tb: self-checking bench of the PES header field parser
// streams well-formed, truncated and corrupt PES headers through the parser
// under varied idle and stall patterns, and checks every field record
// against a behavioral decoder of the same header syntax
// ----------------------------------------------------------------------------
module pes_header_field_parser_tb;

	localparam int HoldCycles    = 400;
	localparam int WatchdogLimit = 4000;
	localparam int PhaseBytes    = 110;
	localparam int TailCycles    = 20;

	// parse steps of the decoder
	localparam int PsIdle     = 0;
	localparam int PsStart    = 1;
	localparam int PsId       = 2;
	localparam int PsLen      = 3;
	localparam int PsFlag1    = 4;
	localparam int PsFlag2    = 5;
	localparam int PsHlen     = 6;
	localparam int PsPts      = 7;
	localparam int PsDts      = 8;
	localparam int PsEscr     = 9;
	localparam int PsRate     = 10;
	localparam int PsTrick    = 11;
	localparam int PsCopy     = 12;
	localparam int PsCrc      = 13;
	localparam int PsExt      = 14;
	localparam int PsPriv     = 15;
	localparam int PsPackLen  = 16;
	localparam int PsPackSkip = 17;
	localparam int PsSeq      = 18;
	localparam int PsPstd     = 19;
	localparam int PsExt2     = 20;
	localparam int PsDone     = 21;

	// stream ids without the optional header
	localparam logic [7:0] SidProgMap   = 8'hBC;
	localparam logic [7:0] SidPadding   = 8'hBE;
	localparam logic [7:0] SidPrivate2  = 8'hBF;
	localparam logic [7:0] SidEcm       = 8'hF0;
	localparam logic [7:0] SidEmm       = 8'hF1;
	localparam logic [7:0] SidDsmcc     = 8'hF2;
	localparam logic [7:0] SidH222E     = 8'hF8;
	localparam logic [7:0] SidDirectory = 8'hFF;

	// trick modes
	localparam logic [2:0] TrickFastFwd = 3'd0;
	localparam logic [2:0] TrickSlow    = 3'd1;
	localparam logic [2:0] TrickFreeze  = 3'd2;
	localparam logic [2:0] TrickFastRev = 3'd3;
	localparam logic [2:0] TrickSlowRev = 3'd4;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
	} beat_t;

	logic                             clk      = 1'b0;
	logic                             arst_n;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [pes_hdr_pkg::InDataW-1:0]  s_tdata  = '0;
	logic [0:0]                       s_tuser  = '0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [pes_hdr_pkg::OutDataW-1:0] m_tdata;
	logic                             m_tlast;

	beat_t             byte_q[$];
	pes_hdr_pkg::rec_t field_recs_due[$];
	pes_hdr_pkg::rec_t want_rec;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatch_cnt   = 0;
	int quiet_cycles   = 0;
	bit hold_go        = 1'b0;
	bit hold_armed     = 1'b0;
	int hold_cnt       = 0;

	// decoder state
	int         pstep     = PsIdle;
	logic [3:0] fbyte     = '0;
	logic [63:0] accum    = '0;
	logic [7:0] sid_reg   = '0;
	logic [7:0] opt_flags = '0;
	logic [7:0] ext_flags = '0;
	logic [7:0] hdr_left  = '0;

	pes_header_field_parser u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit has_optional(logic [7:0] id);
		case (id)
			SidProgMap, SidPadding, SidPrivate2, SidEcm,
			SidEmm, SidDsmcc, SidH222E, SidDirectory: return 1'b0;
			default: return 1'b1;
		endcase
	endfunction

	function automatic bit field_on(int st);
		logic [1:0] pd;
		pd = opt_flags[7:6];
		case (st)
			PsPts:     return pd >= 2'd2;
			PsDts:     return pd == 2'd3;
			PsEscr:    return opt_flags[5];
			PsRate:    return opt_flags[4];
			PsTrick:   return opt_flags[3];
			PsCopy:    return opt_flags[2];
			PsCrc:     return opt_flags[1];
			PsExt:     return opt_flags[0];
			PsPriv:    return opt_flags[0] && ext_flags[7];
			PsPackLen: return opt_flags[0] && ext_flags[6];
			PsSeq:     return opt_flags[0] && ext_flags[5];
			PsPstd:    return opt_flags[0] && ext_flags[4];
			PsExt2:    return opt_flags[0] && ext_flags[0];
			default:   return 1'b0;
		endcase
	endfunction

	function automatic int next_field(int from);
		int s;
		for (s = from + 1; s <= PsExt2; s++)
			if (field_on(s))
				return s;
		return PsDone;
	endfunction

	task automatic add_rec(logic [4:0] code, logic [63:0] value, bit last);
		pes_hdr_pkg::rec_t r;
		r.code  = code;
		r.value = value;
		r.last  = last;
		field_recs_due.push_back(r);
	endtask

	task automatic enter(int st);
		pstep = st;
		fbyte = '0;
		accum = '0;
	endtask

	// record that ends a field, then on to the next announced field
	task automatic close_field(int st, logic [4:0] code, logic [63:0] v);
		int nx;
		nx = next_field(st);
		add_rec(code, v, nx == PsDone);
		enter(nx);
	endtask

	task automatic decode_pes_byte(logic [7:0] b, logic first);
		logic [63:0] a;
		logic [3:0]  idx;
		logic [2:0]  mode;
		logic [4:0]  sub;
		idx = fbyte;
		if (first) begin
			opt_flags = '0;
			ext_flags = '0;
			hdr_left  = '0;
			pstep     = PsStart;
			accum     = {56'b0, b};
			fbyte     = 4'd1;
		end else begin
			if (pstep > PsHlen && hdr_left != 8'd0)
				hdr_left = hdr_left - 8'd1;
			a = {accum[55:0], b};
			case (pstep)
				PsStart: begin
					if (idx < 4'd2) begin
						accum = a;
						fbyte = idx + 4'd1;
					end else if (a[23:0] == 24'h000001) begin
						add_rec(pes_hdr_pkg::CodeStart, 64'(a[23:0]), 1'b0);
						enter(PsId);
					end else begin
						add_rec(pes_hdr_pkg::CodeBadStart, 64'(a[23:0]), 1'b1);
						enter(PsIdle);
					end
				end
				PsId: begin
					sid_reg = b;
					add_rec(pes_hdr_pkg::CodeStreamId, 64'(b), !has_optional(b));
					enter(PsLen);
				end
				PsLen: begin
					if (idx < 4'd1) begin
						accum = a;
						fbyte = 4'd1;
					end else begin
						add_rec(pes_hdr_pkg::CodeLength, 64'(a[15:0]), !has_optional(sid_reg));
						enter(has_optional(sid_reg) ? PsFlag1 : PsDone);
					end
				end
				PsFlag1: begin
					add_rec(pes_hdr_pkg::CodeFlag1, 64'(b[5:0]), 1'b0);
					enter(PsFlag2);
				end
				PsFlag2: begin
					opt_flags = b;
					add_rec(pes_hdr_pkg::CodeFlag2, 64'(b), 1'b0);
					enter(PsHlen);
				end
				PsHlen: begin
					hdr_left = b;
					close_field(PsHlen, pes_hdr_pkg::CodeHdrLen, 64'(b));
				end
				PsPts, PsDts: begin
					if (idx < 4'd4) begin
						accum = a;
						fbyte = idx + 4'd1;
					end else begin
						close_field(pstep,
							pstep == PsPts ? pes_hdr_pkg::CodePts : pes_hdr_pkg::CodeDts,
							64'({a[35:33], a[31:17], a[15:1]}));
					end
				end
				PsEscr: begin
					if (idx < 4'd5) begin
						accum = a;
						fbyte = idx + 4'd1;
					end else begin
						add_rec(pes_hdr_pkg::CodeEscrBase,
							64'({a[45:43], a[41:27], a[25:11]}), 1'b0);
						close_field(PsEscr, pes_hdr_pkg::CodeEscrExt, 64'(a[9:1]));
					end
				end
				PsRate: begin
					if (idx < 4'd2) begin
						accum = a;
						fbyte = idx + 4'd1;
					end else begin
						close_field(PsRate, pes_hdr_pkg::CodeEsRate, 64'(a[22:1]));
					end
				end
				PsTrick: begin
					mode = b[7:5];
					case (mode)
						TrickFastFwd, TrickFastRev, TrickSlow, TrickSlowRev: sub = b[4:0];
						TrickFreeze: sub = {b[4:3], 3'b000};
						default: sub = '0;
					endcase
					close_field(PsTrick, pes_hdr_pkg::CodeTrick, 64'({mode, sub}));
				end
				PsCopy: close_field(PsCopy, pes_hdr_pkg::CodeCopy, 64'(b[6:0]));
				PsCrc: begin
					if (idx < 4'd1) begin
						accum = a;
						fbyte = 4'd1;
					end else begin
						close_field(PsCrc, pes_hdr_pkg::CodeCrc, 64'(a[15:0]));
					end
				end
				PsExt: begin
					ext_flags = b;
					close_field(PsExt, pes_hdr_pkg::CodeExtFlags, 64'(b));
				end
				PsPriv: begin
					// 16 bytes split into two 64-bit records
					if (idx == 4'd7) begin
						add_rec(pes_hdr_pkg::CodePrivHi, a, 1'b0);
						accum = '0;
						fbyte = 4'd8;
					end else if (idx >= 4'd15) begin
						close_field(PsPriv, pes_hdr_pkg::CodePrivLo, a);
					end else begin
						accum = a;
						fbyte = idx + 4'd1;
					end
				end
				PsPackLen: begin
					add_rec(pes_hdr_pkg::CodePackLen, 64'(b), next_field(PsPackSkip) == PsDone);
					if (b != 8'd0) begin
						enter(PsPackSkip);
						accum = {56'b0, b};
					end else begin
						enter(next_field(PsPackSkip));
					end
				end
				PsPackSkip: begin
					if (accum > 64'd1)
						accum = accum - 64'd1;
					else
						enter(next_field(PsPackSkip));
				end
				PsSeq: begin
					if (idx < 4'd1) begin
						add_rec(pes_hdr_pkg::CodeSeqCnt, 64'(b[6:0]), 1'b0);
						fbyte = 4'd1;
					end else begin
						add_rec(pes_hdr_pkg::CodeMpegId, 64'(b[6]), 1'b0);
						close_field(PsSeq, pes_hdr_pkg::CodeStuffLen, 64'(b[5:0]));
					end
				end
				PsPstd: begin
					if (idx < 4'd1) begin
						accum = a;
						fbyte = 4'd1;
					end else begin
						close_field(PsPstd, pes_hdr_pkg::CodePstd, 64'(a[13:0]));
					end
				end
				PsExt2: close_field(PsExt2, pes_hdr_pkg::CodeExt2Len, 64'(b[6:0]));
				default: ;
			endcase
		end
	endtask

	// ---------------- stimulus helpers ----------------

	task automatic send(logic [7:0] d, logic f);
		beat_t bt;
		bt.data  = d;
		bt.first = f;
		byte_q.push_back(bt);
	endtask

	task automatic send_rand(int n);
		int k;
		for (k = 0; k < n; k++)
			send(8'($urandom_range(255)), 1'b0);
	endtask

	task automatic send_start(logic [7:0] sid);
		send(8'h00, 1'b1);
		send(8'h00, 1'b0);
		send(8'h01, 1'b0);
		send(sid, 1'b0);
	endtask

	// one well-formed header with random flags and content, then payload
	task automatic queue_pes(output int n);
		logic [7:0] sid;
		logic [7:0] f2;
		logic [7:0] ef;
		logic [7:0] pl;
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(7))
				0: sid = SidProgMap;
				1: sid = SidPadding;
				2: sid = SidPrivate2;
				3: sid = SidEcm;
				4: sid = SidEmm;
				5: sid = SidDsmcc;
				6: sid = SidH222E;
				default: sid = SidDirectory;
			endcase
		end else begin
			sid = 8'($urandom_range(255));
		end
		send_start(sid);
		send_rand(2);
		n = 6;
		if (has_optional(sid)) begin
			f2 = 8'($urandom_range(255));
			send(8'($urandom_range(255)), 1'b0);
			send(f2, 1'b0);
			send(8'($urandom_range(255)), 1'b0);
			n += 3;
			if (f2[7]) begin send_rand(5); n += 5; end
			if (f2[7:6] == 2'b11) begin send_rand(5); n += 5; end
			if (f2[5]) begin send_rand(6); n += 6; end
			if (f2[4]) begin send_rand(3); n += 3; end
			if (f2[3]) begin send_rand(1); n += 1; end
			if (f2[2]) begin send_rand(1); n += 1; end
			if (f2[1]) begin send_rand(2); n += 2; end
			if (f2[0]) begin
				ef = 8'($urandom_range(255));
				send(ef, 1'b0);
				n += 1;
				if (ef[7]) begin send_rand(16); n += 16; end
				if (ef[6]) begin
					// pack headers kept short but for the odd long one
					pl = ($urandom_range(19) == 0) ? 8'($urandom_range(255))
					                               : 8'($urandom_range(3));
					send(pl, 1'b0);
					send_rand(int'(pl));
					n += 1 + int'(pl);
				end
				if (ef[5]) begin send_rand(2); n += 2; end
				if (ef[4]) begin send_rand(2); n += 2; end
				if (ef[0]) begin send_rand(1); n += 1; end
			end
		end
		send_rand($urandom_range(4));
	endtask

	task automatic run_random(int target);
		int done_bytes;
		int n;
		int r;
		done_bytes = 0;
		while (done_bytes < target) begin
			r = $urandom_range(99);
			if (r < 75) begin
				queue_pes(n);
			end else if (r < 85) begin
				// corrupt start code
				send(8'($urandom_range(255)), 1'b1);
				send_rand(2);
				n = 3;
			end else if (r < 95) begin
				// header cut short by the next packet
				n = $urandom_range(10, 1);
				send_start(8'($urandom_range(255)));
				send_rand(n);
				n += 4;
			end else begin
				if ($urandom_range(3) == 0)
					send(8'($urandom_range(255)), 1'b1);
				send_rand($urandom_range(4, 1));
				n = 0;
			end
			done_bytes += n;
		end
	endtask

	task automatic drain();
		while (byte_q.size() != 0 || s_tvalid || field_recs_due.size() != 0)
			@(negedge clk);
	endtask

	// ---------------- driver ----------------

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				byte_q.delete(0);
			if (!s_tvalid || s_tready) begin
				if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= byte_q[0].data;
					s_tuser  <= byte_q[0].first;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------- receiver ----------------

	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_go && !hold_armed) begin
				hold_armed <= 1'b1;
				hold_cnt   <= HoldCycles;
				m_tready   <= 1'b0;
			end else if (hold_cnt != 0) begin
				hold_cnt <= hold_cnt - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// ---------------- monitor and decoder ----------------

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (field_recs_due.size() == 0) begin
					$display("%0t: expected no record, got code %0d value %h last %b",
						$time, m_tdata[4:0], m_tdata[68:5], m_tlast);
					mismatch_cnt++;
				end else begin
					want_rec = field_recs_due.pop_front();
					if (m_tdata[4:0] !== want_rec.code || m_tdata[68:5] !== want_rec.value ||
						m_tlast !== want_rec.last) begin
						$display("%0t: expected code %0d value %h last %b, got code %0d value %h last %b",
							$time, want_rec.code, want_rec.value, want_rec.last,
							m_tdata[4:0], m_tdata[68:5], m_tlast);
						mismatch_cnt++;
					end
				end
			end
			// a byte accepted now can only show up at a later edge
			if (s_tvalid && s_tready)
				decode_pes_byte(s_tdata, s_tuser[0]);
		end
	end

	// ---------------- watchdog ----------------

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WatchdogLimit) begin
				$display("%0t: no beat for %0d cycles", $time, quiet_cycles);
				$display("pes_header_field_parser_tb: FAIL");
				$finish;
			end
		end
	end

	// ---------------- sequence ----------------

	initial begin
		int ph;
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: idle noise, corrupt start codes, no optional header,
		// header with no optional fields, abort in the middle of a header
		send(8'h5A, 1'b0);
		send(8'hFF, 1'b1);
		send(8'hFF, 1'b0);
		send(8'hFF, 1'b0);
		send(8'h00, 1'b1);
		send(8'h00, 1'b0);
		send(8'h02, 1'b0);
		send_start(SidProgMap);
		send(8'h00, 1'b0);
		send(8'h00, 1'b0);
		send(8'hA5, 1'b0);
		send_start(8'hE0);
		send(8'hFF, 1'b0);
		send(8'hFF, 1'b0);
		send(8'hFF, 1'b0);
		send(8'h40, 1'b0);
		send(8'hFF, 1'b0);
		send_start(8'hC0);
		send(8'h12, 1'b0);
		send_start(SidDirectory);
		send(8'hFF, 1'b0);
		send(8'h00, 1'b0);
		drain();

		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_go = 1'b1; end
				1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
				default: begin send_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			run_random(PhaseBytes);
			drain();
		end

		repeat (TailCycles) @(negedge clk);
		if (mismatch_cnt == 0 && field_recs_due.size() == 0)
			$display("pes_header_field_parser_tb: PASS");
		else
			$display("pes_header_field_parser_tb: FAIL");
		$finish;
	end

endmodule
